// ===== rtl/csniff_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csniff_pkg
// Types, charset codes and per-byte judging functions for the Japanese
// charset sniffer.
// ---------------------------------------------------------------------------
package csniff_pkg;

   localparam logic [2:0] CS_UNKNOWN = 3'd0;
   localparam logic [2:0] CS_JIS     = 3'd1;
   localparam logic [2:0] CS_UTF8    = 3'd2;
   localparam logic [2:0] CS_UTF8N   = 3'd3;
   localparam logic [2:0] CS_SJIS    = 3'd4;
   localparam logic [2:0] CS_EUCJP   = 3'd5;

   typedef struct packed {
      logic [7:0] la0;
      logic [7:0] la1;
      logic [1:0] fill;
      logic       alive;
      logic [2:0] cont;
      logic [1:0] gap;
      logic       seen_any;
      logic [2:0] early;
      logic [2:0] scan_verdict;
      logic       scan_decided;
      logic       euc_pair;
      logic       ended;
   } sniff_state_type;

   localparam sniff_state_type SNIFF_RESET = '{
      la0: 8'h00, la1: 8'h00, fill: 2'd0, alive: 1'b1, cont: 3'd0, gap: 2'd0,
      seen_any: 1'b0, early: CS_UNKNOWN, scan_verdict: CS_UNKNOWN,
      scan_decided: 1'b0, euc_pair: 1'b0, ended: 1'b0};

   function automatic logic [3:0] lead_ones(logic [7:0] b);
      logic [3:0] n;
      logic       stop;
      n = 4'd0;
      stop = 1'b0;
      for (int i = 7; i >= 0; i--) begin
         if (!stop && b[i]) begin
            n = n + 4'd1;
         end else begin
            stop = 1'b1;
         end
      end
      return n;
   endfunction

   function automatic logic in_range(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
      return (v >= lo) && (v <= hi);
   endfunction

   function automatic logic [1:0] gap_inc(logic [1:0] g);
      return (g < 2'd2) ? g + 2'd1 : g;
   endfunction

   // Judges one text position on its three-byte window.
   function automatic sniff_state_type judge(sniff_state_type s, logic [7:0] c,
                                             logic [7:0] d, logic [7:0] e);
      sniff_state_type r;
      logic [3:0]      n;
      logic            done;
      logic            skip;
      r = s;
      n = lead_ones(c);
      done = (r.early != CS_UNKNOWN);
      skip = 1'b0;
      if (!done && r.alive) begin
         if (c == 8'h1B && d == 8'h24) begin
            r.early = CS_JIS;
            done = 1'b1;
         end else if (c == 8'hEF && d == 8'hBB && e == 8'hBF) begin
            r.early = CS_UTF8;
            done = 1'b1;
         end else if (r.cont != 3'd0) begin
            if (n == 4'd1) begin
               r.cont = r.cont - 3'd1;
               if (r.cont != 3'd0) begin
                  r.gap = gap_inc(r.gap);
               end
               r.seen_any = 1'b1;
            end else begin
               r.alive = 1'b0;
            end
         end else if (n == 4'd0) begin
            if (c == 8'h0A) begin
               r.gap = r.seen_any ? 2'd2 : 2'd1;
            end
            r.seen_any = 1'b1;
         end else if (n == 4'd1) begin
            r.alive = 1'b0;
         end else begin
            r.cont = 3'(n - 4'd1);
            r.gap = gap_inc(r.gap);
            r.seen_any = 1'b1;
         end
      end
      if (!done && !r.scan_decided) begin
         if (in_range(c, 8'hA1, 8'hFE) && in_range(d, 8'hA1, 8'hFE)) begin
            r.euc_pair = 1'b1;
         end
         if (c == 8'h8E && in_range(d, 8'hA1, 8'hDF)) begin
            if (e == 8'h8E) begin
               r.scan_verdict = CS_EUCJP;
               r.scan_decided = 1'b1;
               skip = 1'b1;
            end
         end else if (c != 8'h8E && in_range(d, 8'h80, 8'hA0)) begin
            r.scan_verdict = CS_SJIS;
            r.scan_decided = 1'b1;
            skip = 1'b1;
         end
         if (!skip && c == 8'h8F) begin
            if (in_range(d, 8'hA1, 8'hFE) && in_range(e, 8'hA1, 8'hFE)) begin
               if (d == 8'hFD || d == 8'hFE || e == 8'hFD || e == 8'hFE) begin
                  r.scan_verdict = CS_EUCJP;
                  r.scan_decided = 1'b1;
               end
            end else if (in_range(d, 8'h80, 8'hA0) && in_range(e, 8'h80, 8'hA0)) begin
               r.scan_verdict = CS_SJIS;
               r.scan_decided = 1'b1;
            end
         end
      end
      return r;
   endfunction

   function automatic sniff_state_type push_byte(sniff_state_type s, logic [7:0] b);
      sniff_state_type r;
      r = s;
      if (s.fill >= 2'd2) begin
         r = judge(s, s.la0, s.la1, b);
         r.la0 = s.la1;
         r.la1 = b;
      end else begin
         if (s.fill[0]) begin
            r.la1 = b;
         end else begin
            r.la0 = b;
         end
         r.fill = s.fill + 2'd1;
      end
      return r;
   endfunction

   function automatic sniff_state_type end_text(sniff_state_type s);
      sniff_state_type r;
      r = s;
      if (s.fill >= 2'd2) begin
         r = judge(r, s.la0, s.la1, 8'h00);
         r = judge(r, s.la1, 8'h00, 8'h00);
      end else if (s.fill == 2'd1) begin
         r = judge(r, s.la0, 8'h00, 8'h00);
      end
      r.fill = 2'd0;
      r.ended = 1'b1;
      return r;
   endfunction

   function automatic logic [2:0] verdict(sniff_state_type s);
      logic [2:0] v;
      v = s.euc_pair ? CS_EUCJP : CS_UNKNOWN;
      if (s.scan_decided) begin
         v = s.scan_verdict;
      end
      if (s.alive && s.cont == 3'd0) begin
         if (s.gap == 2'd0) begin
            v = CS_UNKNOWN;
         end else if (s.gap >= 2'd2) begin
            v = CS_UTF8N;
         end
      end
      if (s.early != CS_UNKNOWN) begin
         v = s.early;
      end
      return v;
   endfunction

endpackage

// ===== rtl/charset_sniffer_utf8_sjis_eucjp_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// charset_sniffer_utf8_sjis_eucjp_core
// Sniffs whether a text buffer is JIS, UTF-8 (with or without BOM),
// Shift-JIS or EUC-JP, one byte per word.
// ---------------------------------------------------------------------------
// Usage:
// The req channel carries one text byte per word plus an is_last flag that
// marks the final word of a buffer. A zero byte ends the text; bytes after
// it are ignored until the word with is_last. The rsp channel carries one
// charset code per buffer, produced only for the word with is_last.
// Each accepted word enters an input register; from there the judging
// logic folds it into the sniffer state over a three-byte window. The code
// for the last word is loaded into the result register, which drives rsp.
// Throughput is one word per cycle. The only stall source is the result
// register: when it holds a code that rsp has not taken, a last word waits
// in the input register, and req_ready drops until the code is taken.
// Ordinary words keep flowing while a code waits.
// After the last word the sniffer state returns to its reset value, so the
// next buffer can follow in the next cycle. Reset empties both registers.
// ---------------------------------------------------------------------------
module charset_sniffer_utf8_sjis_eucjp_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_charset_code
);

   csniff_pkg::sniff_state_type state_ff, state_in, step_st;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_code_ff, rsp_code_in;
   logic       advance;

   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      step_st = state_ff;
      if (!state_ff.ended) begin
         if (in_byte_ff == 8'h00) begin
            step_st = csniff_pkg::end_text(state_ff);
         end else begin
            step_st = csniff_pkg::push_byte(state_ff, in_byte_ff);
         end
      end
      if (in_last_ff && !step_st.ended) begin
         step_st = csniff_pkg::end_text(step_st);
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_code_in  = rsp_code_ff;
      in_valid_in  = in_valid_ff && !advance;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
      if (advance) begin
         state_in = step_st;
         if (in_last_ff) begin
            state_in     = csniff_pkg::SNIFF_RESET;
            rsp_valid_in = 1'b1;
            rsp_code_in  = csniff_pkg::verdict(step_st);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csniff_pkg::SNIFF_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_text_byte;
         in_last_ff <= req_is_last;
      end
      rsp_code_ff <= rsp_code_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_charset_code = rsp_code_ff;

`ifndef SYNTHESIS
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> rsp_valid_ff)
      else $error("Last word did not load a result.");

   a_last_resets_state: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> state_ff == csniff_pkg::SNIFF_RESET)
      else $error("State not cleared after last word.");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.fill <= 2'd2)
      else $error("Lookahead fill out of range.");

   a_held_word_stable: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff)
      && $stable(in_last_ff))
      else $error("Held input word changed.");
`endif

endmodule
